[rtl/pcgb_pkg.sv]
// ----------------------------------------------------------------------------
// pcgb_pkg
// Shared types and constants of the PCG64 bounded random source.
// ----------------------------------------------------------------------------
package pcgb_pkg;

	localparam logic [63:0] MUL_HI = 64'd2549297995355413924;
	localparam logic [63:0] MUL_LO = 64'd4865540595714422341;
	localparam logic [63:0] HALF_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	// Partial product counts of the shared multiplier.
	localparam logic [3:0] MUL_LEN_LCG = 4'd10;
	localparam logic [3:0] MUL_LEN_W64 = 4'd4;
	localparam logic [3:0] MUL_LEN_W32 = 4'd1;

	localparam logic [6:0] DIV_STEPS = 7'd64;

	localparam logic [1:0] REQ_WORD = 2'd0;
	localparam logic [1:0] REQ_HALF = 2'd1;
	localparam logic [1:0] REQ_LEMIRE = 2'd2;
	localparam logic [1:0] REQ_MASKED = 2'd3;

	localparam logic [1:0] CFG_STATE_HI = 2'd0;
	localparam logic [1:0] CFG_STATE_LO = 2'd1;
	localparam logic [1:0] CFG_SEQ_HI = 2'd2;
	localparam logic [1:0] CFG_SEQ_LO = 2'd3;

	typedef enum logic [2:0] {
		OP_ZERO,
		OP_WORD,
		OP_HALF,
		OP_LEM32,
		OP_LEM64,
		OP_MASK32,
		OP_MASK64
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] bound;
		logic [63:0] n;
		logic [63:0] mask;
	} entry_t;

	typedef struct packed {
		logic [1:0] i;
		logic [1:0] j;
	} limb_pair_t;

	// Limb pairs of the low 128 bits of a product; the first four cover 64x64.
	function automatic limb_pair_t limb_pair(input logic [3:0] k);
		limb_pair_t p;
		case (k)
			4'd0: p = '{2'd0, 2'd0};
			4'd1: p = '{2'd0, 2'd1};
			4'd2: p = '{2'd1, 2'd0};
			4'd3: p = '{2'd1, 2'd1};
			4'd4: p = '{2'd0, 2'd2};
			4'd5: p = '{2'd2, 2'd0};
			4'd6: p = '{2'd0, 2'd3};
			4'd7: p = '{2'd1, 2'd2};
			4'd8: p = '{2'd2, 2'd1};
			default: p = '{2'd3, 2'd0};
		endcase
		return p;
	endfunction

endpackage

[rtl/pcgb_front.sv]
// ----------------------------------------------------------------------------
// pcgb_front
// Classifies a request into an operation and prepares its bound, range size
// and covering mask.
// ----------------------------------------------------------------------------
module pcgb_front (
	input  logic [1:0]           req_type,
	input  logic [63:0]          bound,
	output pcgb_pkg::entry_t     entry
);
	import pcgb_pkg::*;

	logic [63:0] m;

	always_comb begin
		m = bound;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		m = m | (m >> 32);
		entry.bound = bound;
		entry.n = bound + 64'd1;
		entry.mask = m;
		case (req_type)
			REQ_WORD: entry.op = OP_WORD;
			REQ_HALF: entry.op = OP_HALF;
			REQ_LEMIRE: begin
				if (bound == 64'd0)
					entry.op = OP_ZERO;
				else if (bound < HALF_MAX)
					entry.op = OP_LEM32;
				else if (bound == HALF_MAX)
					entry.op = OP_HALF;
				else if (bound == WORD_MAX)
					entry.op = OP_WORD;
				else
					entry.op = OP_LEM64;
			end
			default: begin
				if (bound == 64'd0)
					entry.op = OP_ZERO;
				else if (bound <= HALF_MAX)
					entry.op = OP_MASK32;
				else
					entry.op = OP_MASK64;
			end
		endcase
	end

endmodule

[rtl/pcgb_queue.sv]
// ----------------------------------------------------------------------------
// pcgb_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module pcgb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcgb_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output pcgb_pkg::entry_t head
);
	import pcgb_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

[rtl/pcgb_back.sv]
// ----------------------------------------------------------------------------
// pcgb_back
// Seeds and steps the 128-bit generator, draws words and halves, and runs
// the bounded draws with a shared 32x32 multiplier and a serial remainder.
// ----------------------------------------------------------------------------
module pcgb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic             q_not_empty,
	input  pcgb_pkg::entry_t q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata
);
	import pcgb_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_SEED     = 10'b00_0000_0010,
		ST_SEED_ADD = 10'b00_0000_0100,
		ST_FETCH    = 10'b00_0000_1000,
		ST_LMUL     = 10'b00_0001_0000,
		ST_LFIN     = 10'b00_0010_0000,
		ST_DRAW     = 10'b00_0100_0000,
		ST_USE      = 10'b00_1000_0000,
		ST_PMUL     = 10'b01_0000_0000,
		ST_PCHK     = 10'b10_0000_0000
	} state_t;

	state_t       st_q;
	logic         div_busy_q;
	logic         res_busy_q;
	logic [1:0]   seed_phase_q;
	logic [63:0]  init_state_hi_q, init_state_lo_q, init_seq_hi_q, init_seq_lo_q;
	logic [127:0] lcg_q, inc_q, acc_q;
	logic [31:0]  spare_q;
	logic         spare_valid_q;
	entry_t       ent_q;
	logic [63:0]  sample_q, thr_q, res_q, out_q;
	logic         thr_valid_q, out_valid_q;
	logic [3:0]   mul_k_q, mul_len_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic         pv_s1;
	logic [63:0]  rem_q, dvd_q;
	logic [6:0]   div_cnt_q;

	logic         half_path, mul_done, out_free;
	limb_pair_t   pr;
	logic [127:0] op_a, op_b;
	logic [31:0]  a_limb, b_limb;
	logic [63:0]  xw, word;
	logic [127:0] xx;
	logic [63:0]  left, hi_part;
	logic         lt_n, lt_thr;
	logic [64:0]  trial;

	assign half_path = (ent_q.op == OP_HALF) || (ent_q.op == OP_LEM32)
		|| (ent_q.op == OP_MASK32);
	assign mul_done = (mul_k_q == mul_len_q) && !pv_s1;
	assign out_free = !out_valid_q || m_tready;
	assign cfg_ready = (st_q == ST_IDLE) && !res_busy_q;
	assign q_pop = (st_q == ST_IDLE) && !res_busy_q && !cfg_valid && q_not_empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	always_comb begin
		pr = limb_pair(mul_k_q);
		if (st_q == ST_LMUL) begin
			op_a = lcg_q;
			op_b = {MUL_HI, MUL_LO};
		end else begin
			op_a = {64'd0, sample_q};
			op_b = {64'd0, ent_q.n};
		end
		a_limb = op_a[32*pr.i +: 32];
		b_limb = op_b[32*pr.j +: 32];
		xw = lcg_q[127:64] ^ lcg_q[63:0];
		xx = {xw, xw} >> lcg_q[127:122];
		word = xx[63:0];
		if (ent_q.op == OP_LEM32) begin
			left = {32'd0, acc_q[31:0]};
			hi_part = {32'd0, acc_q[63:32]};
		end else begin
			left = acc_q[63:0];
			hi_part = acc_q[127:64];
		end
		lt_n = left < ent_q.n;
		lt_thr = left < thr_q;
		trial = {rem_q, dvd_q[63]};
	end

	// Shared multiplier: one 32x32 partial product per cycle, accumulated later.
	always_ff @(posedge clk) begin
		prod_s1 <= a_limb * b_limb;
		sh_s1 <= pr.i + pr.j;
		if (st_q == ST_SEED || st_q == ST_SEED_ADD || st_q == ST_FETCH || st_q == ST_USE) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			case (sh_s1)
				2'd0: acc_q <= acc_q + {64'd0, prod_s1};
				2'd1: acc_q <= acc_q + {32'd0, prod_s1, 32'd0};
				2'd2: acc_q <= acc_q + {prod_s1, 64'd0};
				default: acc_q <= acc_q + {prod_s1[31:0], 96'd0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_SEED;
			seed_phase_q <= 2'd0;
			init_state_hi_q <= '0;
			init_state_lo_q <= '0;
			init_seq_hi_q <= '0;
			init_seq_lo_q <= '0;
			spare_valid_q <= 1'b0;
			spare_q <= '0;
			thr_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_busy_q <= 1'b0;
			div_busy_q <= 1'b0;
			pv_s1 <= 1'b0;
			mul_k_q <= '0;
			mul_len_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (res_busy_q && out_free) begin
				out_valid_q <= 1'b1;
				out_q <= res_q;
				res_busy_q <= 1'b0;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			pv_s1 <= (st_q == ST_LMUL || st_q == ST_PMUL) && mul_k_q != mul_len_q;
			if ((st_q == ST_LMUL || st_q == ST_PMUL) && mul_k_q != mul_len_q)
				mul_k_q <= mul_k_q + 4'd1;
			unique case (st_q)
				ST_IDLE: begin
					if (!res_busy_q && cfg_valid) begin
						unique case (cfg_index)
							CFG_STATE_HI: init_state_hi_q <= cfg_data;
							CFG_STATE_LO: init_state_lo_q <= cfg_data;
							CFG_SEQ_HI: init_seq_hi_q <= cfg_data;
							default: init_seq_lo_q <= cfg_data;
						endcase
						st_q <= ST_SEED;
					end else if (q_pop) begin
						ent_q <= q_head;
						thr_valid_q <= 1'b0;
						if (q_head.op == OP_ZERO) begin
							res_q <= '0;
							res_busy_q <= 1'b1;
						end else begin
							st_q <= ST_FETCH;
						end
					end
				end
				ST_SEED: begin
					lcg_q <= '0;
					inc_q <= {init_seq_hi_q[62:0], init_seq_lo_q, 1'b1};
					spare_valid_q <= 1'b0;
					spare_q <= '0;
					seed_phase_q <= 2'd1;
					mul_k_q <= '0;
					mul_len_q <= MUL_LEN_LCG;
					st_q <= ST_LMUL;
				end
				ST_SEED_ADD: begin
					lcg_q <= lcg_q + {init_state_hi_q, init_state_lo_q};
					seed_phase_q <= 2'd2;
					mul_k_q <= '0;
					mul_len_q <= MUL_LEN_LCG;
					st_q <= ST_LMUL;
				end
				ST_FETCH: begin
					if (half_path && spare_valid_q) begin
						sample_q <= {32'd0, spare_q};
						spare_valid_q <= 1'b0;
						st_q <= ST_USE;
					end else begin
						mul_k_q <= '0;
						mul_len_q <= MUL_LEN_LCG;
						st_q <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					if (mul_done)
						st_q <= ST_LFIN;
				end
				ST_LFIN: begin
					lcg_q <= acc_q + inc_q;
					if (seed_phase_q == 2'd1) begin
						st_q <= ST_SEED_ADD;
					end else if (seed_phase_q == 2'd2) begin
						seed_phase_q <= 2'd0;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (half_path) begin
						sample_q <= {32'd0, word[31:0]};
						spare_q <= word[63:32];
						spare_valid_q <= 1'b1;
					end else begin
						sample_q <= word;
					end
					st_q <= ST_USE;
				end
				ST_USE: begin
					case (ent_q.op)
						OP_LEM32, OP_LEM64: begin
							mul_k_q <= '0;
							mul_len_q <= (ent_q.op == OP_LEM32) ? MUL_LEN_W32 : MUL_LEN_W64;
							st_q <= ST_PMUL;
						end
						OP_MASK32, OP_MASK64: begin
							if ((sample_q & ent_q.mask) <= ent_q.bound) begin
								res_q <= sample_q & ent_q.mask;
								res_busy_q <= 1'b1;
								st_q <= ST_IDLE;
							end else begin
								st_q <= ST_FETCH;
							end
						end
						default: begin
							res_q <= sample_q;
							res_busy_q <= 1'b1;
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_PMUL: begin
					if (mul_done)
						st_q <= ST_PCHK;
				end
				default: begin
					// Threshold is (range complement) mod n, found one bit per cycle.
					if (div_busy_q) begin
						if (div_cnt_q == DIV_STEPS) begin
							thr_q <= rem_q;
							thr_valid_q <= 1'b1;
							div_busy_q <= 1'b0;
						end else begin
							if (trial >= {1'b0, ent_q.n})
								rem_q <= 64'(trial - {1'b0, ent_q.n});
							else
								rem_q <= trial[63:0];
							dvd_q <= {dvd_q[62:0], 1'b0};
							div_cnt_q <= div_cnt_q + 7'd1;
						end
					end else if (lt_n && !thr_valid_q) begin
						div_busy_q <= 1'b1;
						rem_q <= '0;
						div_cnt_q <= '0;
						if (ent_q.op == OP_LEM32)
							dvd_q <= {32'd0, 32'hFFFF_FFFF - ent_q.bound[31:0]};
						else
							dvd_q <= ~ent_q.bound;
					end else if (lt_n && lt_thr) begin
						st_q <= ST_FETCH;
					end else begin
						res_q <= hi_part;
						res_busy_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

[rtl/pcg64_bounded_random_source_unit.sv]
// ----------------------------------------------------------------------------
// pcg64_bounded_random_source_unit
// PCG64 XSL-RR random source with buffered halves and bounded draws.
//
// Requests enter on the s_ channel (tuser: request kind, tdata: bound) and
// each gives one item on the m_ channel (tdata: value). A front stage
// classifies requests into a two-entry queue; the back stage executes them.
// One generator step uses a shared 32x32 multiplier for ten partial
// products; a buffered spare half is used without a step. A Lemire
// draw adds a 1 or 4 product multiply, and the first near-rejection runs a
// bit-serial remainder for the threshold. Rejections repeat the draw.
// Configuration writes (cfg_ valid/ready, register index and data) are
// taken only when the back stage is idle and start a reseed of two
// generator steps. Reset also runs that seed.
// The output register holds an item while m_tready is low; one more finished
// result can wait behind it and the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module pcg64_bounded_random_source_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] bound
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import pcgb_pkg::*;

	entry_t cls_entry, head;
	logic   full, not_empty, pop;

	assign s_tready = !full;

	pcgb_front u_front (
		.req_type (s_tuser),
		.bound    (s_tdata),
		.entry    (cls_entry)
	);

	pcgb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid && !full),
		.push_entry (cls_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	pcgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

[rtl/pcgb_checker.sv]
// ----------------------------------------------------------------------------
// pcgb_checker
// Port-level checks of the random source, bound to the top level.
// ----------------------------------------------------------------------------
module pcgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A stalled item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output item changed while stalled");

	// A write starts a reseed, during which the port is not ready.
	a_cfg_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cfg_ready ##1 !cfg_ready)
		else $error("configuration port ready during reseed");

endmodule

bind pcg64_bounded_random_source_unit pcgb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

[tb/pcg64_bounded_random_source_unit_test.sv]
// ----------------------------------------------------------------------------
// pcg64_bounded_random_source_unit_test
// Self-checking bench for the PCG64 bounded random source. Requests of every
// kind are sent with random gaps, and every returned item is compared with a
// local generator model that tracks the LCG state, the spare half and the
// seeding configuration. Several seed settings are written between phases.
// ----------------------------------------------------------------------------
module pcg64_bounded_random_source_unit_test;
	import pcgb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	pcg64_bounded_random_source_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Model of the generator.
	logic [127:0] gen_state;
	logic [127:0] gen_inc;
	logic [31:0]  gen_spare;
	logic         gen_spare_ok;
	logic [63:0]  seed_regs [4];

	logic [63:0] expected_values [$];
	int          err_count;
	longint      cycle_count;
	bit          rx_hold;

	localparam logic [127:0] MULT = {MUL_HI, MUL_LO};
	localparam longint CYCLE_LIMIT = 3000000;

	function automatic logic [63:0] next_word();
		logic [63:0] x;
		logic [5:0]  r;
		gen_state = gen_state * MULT + gen_inc;
		x = gen_state[127:64] ^ gen_state[63:0];
		r = gen_state[127:122];
		return (x >> r) | (x << ((64 - r) & 63));
	endfunction

	function automatic logic [31:0] next_half();
		logic [63:0] w;
		if (gen_spare_ok) begin
			gen_spare_ok = 1'b0;
			return gen_spare;
		end
		w = next_word();
		gen_spare = w[63:32];
		gen_spare_ok = 1'b1;
		return w[31:0];
	endfunction

	function automatic void reseed();
		gen_state = '0;
		gen_inc = {seed_regs[CFG_SEQ_HI][62:0], seed_regs[CFG_SEQ_LO], 1'b1};
		gen_state = gen_state * MULT + gen_inc;
		gen_state = gen_state + {seed_regs[CFG_STATE_HI], seed_regs[CFG_STATE_LO]};
		gen_state = gen_state * MULT + gen_inc;
		gen_spare = '0;
		gen_spare_ok = 1'b0;
	endfunction

	function automatic logic [63:0] predict_draw(logic [1:0] kind, logic [63:0] bound);
		logic [63:0]  n64;
		logic [63:0]  mask;
		logic [63:0]  v;
		logic [63:0]  thr;
		logic [127:0] m;
		case (kind)
			REQ_WORD: return next_word();
			REQ_HALF: return {32'd0, next_half()};
			REQ_LEMIRE: begin
				if (bound == 64'd0) return 64'd0;
				if (bound == HALF_MAX) return {32'd0, next_half()};
				if (bound == WORD_MAX) return next_word();
				n64 = bound + 64'd1;
				if (bound < HALF_MAX) begin
					m = {96'd0, next_half()} * n64;
					if (m[31:0] < n64) begin
						thr = (HALF_MAX - bound) % n64;
						while (m[31:0] < thr) m = {96'd0, next_half()} * n64;
					end
					return {32'd0, m[63:32]};
				end
				m = {64'd0, next_word()} * n64;
				if (m[63:0] < n64) begin
					thr = (WORD_MAX - bound) % n64;
					while (m[63:0] < thr) m = {64'd0, next_word()} * n64;
				end
				return m[127:64];
			end
			default: begin
				if (bound == 64'd0) return 64'd0;
				mask = bound;
				for (int s = 1; s < 64; s = s * 2) mask = mask | (mask >> s);
				do begin
					if (bound <= HALF_MAX) v = {32'd0, next_half()} & mask;
					else v = next_word() & mask;
				end while (v > bound);
				return v;
			end
		endcase
	endfunction

	// Check side.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$error("value: unexpected item %h", m_tdata);
				err_count++;
			end else begin
				if (m_tdata !== expected_values[0]) begin
					$error("value: expected %h actual %h", expected_values[0], m_tdata);
					err_count++;
				end
				void'(expected_values.pop_front());
			end
		end
	end

	// Receiver stalls: random per item, or a long hold-off on request.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] kind, logic [63:0] bound, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= bound;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_values.insert(expected_values.size(), predict_draw(kind, bound));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_values.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// The caller drops cfg_valid after its last write.
	task automatic write_seed_reg(logic [1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		seed_regs[idx] = val;
		reseed();
	endtask

	function automatic logic [63:0] rand_bound();
		logic [63:0] b;
		int w;
		b = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: return 64'($urandom_range(0, 3));
			1: return HALF_MAX - $urandom_range(0, 2);
			2: return WORD_MAX - $urandom_range(0, 2);
			3: return 64'h8000_0000 + $urandom_range(0, 1);
			4: return 64'h8000_0000_0000_0000 + $urandom_range(0, 1);
			default: begin
				w = $urandom_range(1, 64);
				return (w == 64) ? b : (b & ((64'd1 << w) - 1));
			end
		endcase
	endfunction

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] bound;
		logic        known;
		logic [63:0] value;
	} directed_row_t;

	directed_row_t directed_rows [] = '{
		'{REQ_LEMIRE, 64'd0, 1'b1, 64'd0},
		'{REQ_MASKED, 64'd0, 1'b1, 64'd0},
		'{REQ_WORD, 64'd0, 1'b0, 64'd0},
		'{REQ_HALF, WORD_MAX, 1'b0, 64'd0},
		'{REQ_HALF, 64'd0, 1'b0, 64'd0},
		'{REQ_HALF, 64'd0, 1'b0, 64'd0},
		'{REQ_WORD, 64'd0, 1'b0, 64'd0},
		'{REQ_HALF, 64'd0, 1'b0, 64'd0},
		'{REQ_WORD, 64'd0, 1'b0, 64'd0},
		'{REQ_HALF, 64'd0, 1'b0, 64'd0},
		'{REQ_LEMIRE, 64'd1, 1'b0, 64'd0},
		'{REQ_LEMIRE, 64'd2, 1'b0, 64'd0},
		'{REQ_LEMIRE, HALF_MAX - 1, 1'b0, 64'd0},
		'{REQ_LEMIRE, HALF_MAX, 1'b0, 64'd0},
		'{REQ_LEMIRE, HALF_MAX + 1, 1'b0, 64'd0},
		'{REQ_LEMIRE, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
		'{REQ_LEMIRE, WORD_MAX - 1, 1'b0, 64'd0},
		'{REQ_LEMIRE, WORD_MAX, 1'b0, 64'd0},
		'{REQ_MASKED, 64'd1, 1'b0, 64'd0},
		'{REQ_MASKED, 64'd5, 1'b0, 64'd0},
		'{REQ_MASKED, HALF_MAX, 1'b0, 64'd0},
		'{REQ_MASKED, HALF_MAX + 1, 1'b0, 64'd0},
		'{REQ_MASKED, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
		'{REQ_MASKED, WORD_MAX, 1'b0, 64'd0}
	};

	initial begin
		logic [63:0] seed_sets [4][4];
		err_count = 0;
		cycle_count = 0;
		rx_hold = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_WORD;
		cfg_valid = 1'b0;
		cfg_index = CFG_STATE_HI;
		cfg_data = '0;
		for (int i = 0; i < 4; i++) seed_regs[i] = '0;
		reseed();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].kind, directed_rows[i].bound, $urandom_range(0, 3));
			if (directed_rows[i].known && expected_values[$] !== directed_rows[i].value) begin
				$error("value: expected %h actual %h", directed_rows[i].value, expected_values[$]);
				err_count++;
			end
		end
		drain_results();

		seed_sets[0] = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
		seed_sets[1] = '{64'd0, 64'd42, 64'd0, 64'd54};
		seed_sets[2] = '{{$urandom(), $urandom()}, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, {$urandom(), $urandom()}};
		seed_sets[3] = '{64'd0, 64'd0, 64'd0, 64'd0};
		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 4; r++) write_seed_reg(r[1:0], seed_sets[p][r]);
			cfg_valid <= 1'b0;
			if (p == 1) rx_hold = 1'b1;
			for (int k = 0; k < 430; k++) begin
				send_request(2'($urandom_range(0, 3)), rand_bound(),
					($urandom_range(0, 3) == 0 || p == 1) ? 0 : $urandom_range(0, 15));
				if (k == 200) drain_results();
			end
			drain_results();
		end

		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
